// ===== design/sbc_pkg.sv =====
// sbc_pkg: shared types, round constants and mixing functions for the
// SHA-256 block compression pipeline. No dependencies.
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned WinWords  = 16;

  typedef logic [31:0] word_t;

  localparam word_t K [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One pipeline stage: working words (index 0 = A .. 7 = H), the
  // pre-added H + K + W for the coming round, the schedule window
  // (index 0 = word of the coming round) and the saved chaining input.
  typedef struct packed {
    word_t [7:0]          v;
    word_t                hkw;
    word_t [WinWords-1:0] w;
    word_t [7:0]          h_in;
  } stage_t;

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== design/sbc_if.sv =====
// sbc_if: valid/ready stream interfaces for the compression pipeline,
// one for the input item and one for the result. No dependencies.
`timescale 1ns / 1ps

interface sbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] state_ab;
  logic [63:0] state_cd;
  logic [63:0] state_ef;
  logic [63:0] state_gh;
  logic [63:0] block_bytes_0_7;
  logic [63:0] block_bytes_8_15;
  logic [63:0] block_bytes_16_23;
  logic [63:0] block_bytes_24_31;
  logic [63:0] block_bytes_32_39;
  logic [63:0] block_bytes_40_47;
  logic [63:0] block_bytes_48_55;
  logic [63:0] block_bytes_56_63;

  modport source (
    output valid, state_ab, state_cd, state_ef, state_gh,
    block_bytes_0_7, block_bytes_8_15, block_bytes_16_23, block_bytes_24_31,
    block_bytes_32_39, block_bytes_40_47, block_bytes_48_55, block_bytes_56_63,
    input  ready
  );
  modport sink (
    input  valid, state_ab, state_cd, state_ef, state_gh,
    block_bytes_0_7, block_bytes_8_15, block_bytes_16_23, block_bytes_24_31,
    block_bytes_32_39, block_bytes_40_47, block_bytes_48_55, block_bytes_56_63,
    output ready
  );
endinterface

interface sbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] new_ab;
  logic [63:0] new_cd;
  logic [63:0] new_ef;
  logic [63:0] new_gh;

  modport source (output valid, new_ab, new_cd, new_ef, new_gh, input ready);
  modport sink   (input  valid, new_ab, new_cd, new_ef, new_gh, output ready);
endinterface

// ===== design/sbc_round.sv =====
// sbc_round: one compression round plus one schedule expansion step,
// registered. Depends on sbc_pkg.
`timescale 1ns / 1ps

module sbc_round #(
  parameter int unsigned ROUND = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  input  sbc_pkg::stage_t up_data,
  output logic            up_ready,
  output logic            dn_valid,
  output sbc_pkg::stage_t dn_data,
  input  logic            dn_ready
);

  localparam int unsigned NextRound = (ROUND + 1) % sbc_pkg::NumRounds;

  sbc_pkg::word_t  t1;
  sbc_pkg::word_t  t2;
  sbc_pkg::stage_t stage_next;

  always_comb begin
    t1 = up_data.hkw + sbc_pkg::big_sigma1(up_data.v[4])
       + sbc_pkg::choose(up_data.v[4], up_data.v[5], up_data.v[6]);
    t2 = sbc_pkg::big_sigma0(up_data.v[0])
       + sbc_pkg::majority(up_data.v[0], up_data.v[1], up_data.v[2]);

    stage_next.v[0] = t1 + t2;
    stage_next.v[1] = up_data.v[0];
    stage_next.v[2] = up_data.v[1];
    stage_next.v[3] = up_data.v[2];
    stage_next.v[4] = up_data.v[3] + t1;
    stage_next.v[5] = up_data.v[4];
    stage_next.v[6] = up_data.v[5];
    stage_next.v[7] = up_data.v[6];

    // shift the schedule window and append the next expanded word
    for (int j = 0; j < sbc_pkg::WinWords - 1; j++) begin
      stage_next.w[j] = up_data.w[j+1];
    end
    stage_next.w[sbc_pkg::WinWords-1] = sbc_pkg::small_sigma1(up_data.w[14]) + up_data.w[9]
                                      + sbc_pkg::small_sigma0(up_data.w[1]) + up_data.w[0];

    // G of this round is H of the next one
    stage_next.hkw  = up_data.v[6] + sbc_pkg::K[NextRound] + up_data.w[1];
    stage_next.h_in = up_data.h_in;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= stage_next;
    end
  end

endmodule

// ===== design/sha256_block_compress.sv =====
// sha256_block_compress: fully unrolled SHA-256 compression, one round per
// stage. Depends on sbc_pkg, sbc_if and sbc_round.
//
//   channel   dir   handshake     payload
//   in        sink  valid/ready   state_ab..state_gh, block_bytes_0_7..56_63
//   out       src   valid/ready   new_ab, new_cd, new_ef, new_gh
//
// Takes one block per cycle unless a stall at the output backs up to the input;
// the result passes through 66 registers (input register, 64 round stages,
// output register with the final add). Each round stage holds the adds of
// one round.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// close up and a stall at the output holds every full stage in place.
// Reset clears the valid bits and the occupancy count only; the round constants are fixed logic.
`timescale 1ns / 1ps

module sha256_block_compress (
  input  logic clk,
  input  logic rst,
  sbc_in_if.sink    in,
  sbc_out_if.source out
);

  localparam int unsigned Depth = sbc_pkg::NumRounds + 2;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [sbc_pkg::NumRounds:0] st_valid;
  logic [sbc_pkg::NumRounds:0] st_ready;
  sbc_pkg::stage_t             st_data [sbc_pkg::NumRounds+1];
  sbc_pkg::stage_t             in_stage;
  sbc_pkg::stage_t             last;
  logic                        in_xfer;

  // input register: unpack words and pre-add H + K + W for round 0
  always_comb begin
    in_stage.v[0] = in.state_ab[63:32];
    in_stage.v[1] = in.state_ab[31:0];
    in_stage.v[2] = in.state_cd[63:32];
    in_stage.v[3] = in.state_cd[31:0];
    in_stage.v[4] = in.state_ef[63:32];
    in_stage.v[5] = in.state_ef[31:0];
    in_stage.v[6] = in.state_gh[63:32];
    in_stage.v[7] = in.state_gh[31:0];
    in_stage.h_in = in_stage.v;
    in_stage.w[0]  = in.block_bytes_0_7[63:32];
    in_stage.w[1]  = in.block_bytes_0_7[31:0];
    in_stage.w[2]  = in.block_bytes_8_15[63:32];
    in_stage.w[3]  = in.block_bytes_8_15[31:0];
    in_stage.w[4]  = in.block_bytes_16_23[63:32];
    in_stage.w[5]  = in.block_bytes_16_23[31:0];
    in_stage.w[6]  = in.block_bytes_24_31[63:32];
    in_stage.w[7]  = in.block_bytes_24_31[31:0];
    in_stage.w[8]  = in.block_bytes_32_39[63:32];
    in_stage.w[9]  = in.block_bytes_32_39[31:0];
    in_stage.w[10] = in.block_bytes_40_47[63:32];
    in_stage.w[11] = in.block_bytes_40_47[31:0];
    in_stage.w[12] = in.block_bytes_48_55[63:32];
    in_stage.w[13] = in.block_bytes_48_55[31:0];
    in_stage.w[14] = in.block_bytes_56_63[63:32];
    in_stage.w[15] = in.block_bytes_56_63[31:0];
    in_stage.hkw = in_stage.v[7] + sbc_pkg::K[0] + in_stage.w[0];
  end

  assign in.ready = !st_valid[0] || st_ready[0];
  assign in_xfer  = in.valid && in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (in.ready) begin
      st_valid[0] <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      st_data[0] <= in_stage;
    end
  end

  for (genvar r = 0; r < sbc_pkg::NumRounds; r++) begin : g_round
    sbc_round #(.ROUND(r)) u_round (
      .clk      (clk),
      .rst      (rst),
      .up_valid (st_valid[r]),
      .up_data  (st_data[r]),
      .up_ready (st_ready[r]),
      .dn_valid (st_valid[r+1]),
      .dn_data  (st_data[r+1]),
      .dn_ready (st_ready[r+1])
    );
  end

  // output register: add the saved chaining words back in
  assign last = st_data[sbc_pkg::NumRounds];
  assign st_ready[sbc_pkg::NumRounds] = !out.valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (st_ready[sbc_pkg::NumRounds]) begin
      out.valid <= st_valid[sbc_pkg::NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid[sbc_pkg::NumRounds] && st_ready[sbc_pkg::NumRounds]) begin
      out.new_ab <= {last.h_in[0] + last.v[0], last.h_in[1] + last.v[1]};
      out.new_cd <= {last.h_in[2] + last.v[2], last.h_in[3] + last.v[3]};
      out.new_ef <= {last.h_in[4] + last.v[4], last.h_in[5] + last.v[5]};
      out.new_gh <= {last.h_in[6] + last.v[6], last.h_in[7] + last.v[7]};
    end
  end

  // occupancy, for the checks below
  logic [CntW-1:0] in_flight;
  logic            out_xfer;

  assign out_xfer = out.valid && out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (in_xfer && !out_xfer) begin
      in_flight <= in_flight + CntW'(1);
    end else if (out_xfer && !in_xfer) begin
      in_flight <= in_flight - CntW'(1);
    end
  end

  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CntW'(Depth))
    else $error("more blocks in flight than pipeline stages");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> in_flight != '0)
    else $error("result valid with no block in flight");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out.valid |-> in.ready)
    else $error("input stalled while output register is empty");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (in_flight == CntW'(Depth)) && !out.ready |-> !in.ready)
    else $error("input taken while every stage is full and output stalled");

endmodule

// ===== test/sbc_compress_check.sv =====
// sbc_compress_check: watches both channels of sha256_block_compress, computes
// the expected chaining state for every input transfer and compares results.
// Depends on sbc_pkg (word type) and sbc_if (channel interfaces).
`timescale 1ns / 1ps

module sbc_compress_check (
  input  logic        clk,
  input  logic        rst,
  sbc_in_if           in_ch,
  sbc_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned MaxReports = 10;

  localparam sbc_pkg::word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam string FieldName [4] = '{"new_ab", "new_cd", "new_ef", "new_gh"};

  logic [255:0] expected_digests [$];
  logic [255:0] chain_in;
  logic [511:0] msg_in;
  logic [255:0] digest_got;
  logic [255:0] digest_want;

  function automatic sbc_pkg::word_t ror(input sbc_pkg::word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic sbc_pkg::word_t ep0(input sbc_pkg::word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic sbc_pkg::word_t ep1(input sbc_pkg::word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic sbc_pkg::word_t sig0(input sbc_pkg::word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic sbc_pkg::word_t sig1(input sbc_pkg::word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  // Word 0 (A) sits in the top 32 bits of the chain, W0 in the top of the message.
  function automatic logic [255:0] compress_block(input logic [255:0] chain,
                                                  input logic [511:0] msg);
    sbc_pkg::word_t sched [64];
    sbc_pkg::word_t start [8];
    sbc_pkg::word_t wv [8];
    sbc_pkg::word_t t1;
    sbc_pkg::word_t t2;
    logic [255:0]   digest;
    for (int i = 0; i < 8; i++) begin
      start[i] = chain[255 - 32 * i -: 32];
      wv[i]    = start[i];
    end
    for (int i = 0; i < 16; i++) sched[i] = msg[511 - 32 * i -: 32];
    for (int i = 16; i < 64; i++) begin
      sched[i] = sig1(sched[i - 2]) + sched[i - 7] + sig0(sched[i - 15]) + sched[i - 16];
    end
    for (int i = 0; i < 64; i++) begin
      t1 = wv[7] + ep1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + RoundK[i] + sched[i];
      t2 = ep0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
      wv[7] = wv[6];
      wv[6] = wv[5];
      wv[5] = wv[4];
      wv[4] = wv[3] + t1;
      wv[3] = wv[2];
      wv[2] = wv[1];
      wv[1] = wv[0];
      wv[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      t1 = start[i] + wv[i];
      digest[255 - 32 * i -: 32] = t1;
    end
    return digest;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        chain_in = {in_ch.state_ab, in_ch.state_cd, in_ch.state_ef, in_ch.state_gh};
        msg_in   = {in_ch.block_bytes_0_7,   in_ch.block_bytes_8_15,
                    in_ch.block_bytes_16_23, in_ch.block_bytes_24_31,
                    in_ch.block_bytes_32_39, in_ch.block_bytes_40_47,
                    in_ch.block_bytes_48_55, in_ch.block_bytes_56_63};
        expected_digests.push_back(compress_block(chain_in, msg_in));
      end
      if (out_ch.valid && out_ch.ready) begin
        digest_got = {out_ch.new_ab, out_ch.new_cd, out_ch.new_ef, out_ch.new_gh};
        if (expected_digests.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("[%0t] result transfer with nothing outstanding: %h", $realtime,
                     digest_got);
        end else begin
          digest_want = expected_digests.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (digest_got[255 - 64 * f -: 64] !== digest_want[255 - 64 * f -: 64]) begin
              fail_count++;
              if (fail_count <= MaxReports)
                $display("[%0t] %s mismatch: expected %h, got %h", $realtime,
                         FieldName[f], digest_want[255 - 64 * f -: 64],
                         digest_got[255 - 64 * f -: 64]);
            end
          end
        end
      end
      pending = expected_digests.size();
    end
  end

endmodule

// ===== test/tb_sha256_block_compress.sv =====
// tb_sha256_block_compress: drives chaining states and message blocks into
// sha256_block_compress under random back-pressure; sbc_compress_check checks.
// Depends on sbc_pkg, sbc_if, the block itself and sbc_compress_check.
`timescale 1ns / 1ps

module tb_sha256_block_compress;

  localparam int unsigned NumRandom      = 800;
  localparam int unsigned CalmTail       = 100;
  localparam int unsigned LongHoldAt     = 150;
  localparam int unsigned LongHoldCycles = 250;
  localparam int unsigned DrainCycles    = 80;
  localparam int unsigned LimitCycles    = 200000;

  localparam logic [255:0] ShaIv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  // "abc" after padding: one block, length 24 bits
  localparam logic [511:0] AbcBlock = {32'h61626380, 416'd0, 64'h18};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          calm;
  bit          hold_out;
  int unsigned fail_count;
  int unsigned pending;

  sbc_in_if  in_ch ();
  sbc_out_if out_ch ();

  sha256_block_compress dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  sbc_compress_check u_check (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly random words, with some all-zero, all-one and one-hot words mixed in.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [255:0] rand_chain();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32 * i +: 32] = rand_word();
    return v;
  endfunction

  function automatic logic [511:0] rand_msg();
    logic [511:0] v;
    for (int i = 0; i < 16; i++) v[32 * i +: 32] = rand_word();
    return v;
  endfunction

  // Call at a rising edge; returns at the edge where the transfer happens.
  task automatic send_block(input logic [255:0] chain, input logic [511:0] msg);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.state_ab          <= chain[255:192];
    in_ch.state_cd          <= chain[191:128];
    in_ch.state_ef          <= chain[127:64];
    in_ch.state_gh          <= chain[63:0];
    in_ch.block_bytes_0_7   <= msg[511:448];
    in_ch.block_bytes_8_15  <= msg[447:384];
    in_ch.block_bytes_16_23 <= msg[383:320];
    in_ch.block_bytes_24_31 <= msg[319:256];
    in_ch.block_bytes_32_39 <= msg[255:192];
    in_ch.block_bytes_40_47 <= msg[191:128];
    in_ch.block_bytes_48_55 <= msg[127:64];
    in_ch.block_bytes_56_63 <= msg[63:0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    in_ch.valid             <= 1'b0;
    in_ch.state_ab          <= '0;
    in_ch.state_cd          <= '0;
    in_ch.state_ef          <= '0;
    in_ch.state_gh          <= '0;
    in_ch.block_bytes_0_7   <= '0;
    in_ch.block_bytes_8_15  <= '0;
    in_ch.block_bytes_16_23 <= '0;
    in_ch.block_bytes_24_31 <= '0;
    in_ch.block_bytes_32_39 <= '0;
    in_ch.block_bytes_40_47 <= '0;
    in_ch.block_bytes_48_55 <= '0;
    in_ch.block_bytes_56_63 <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // extremes, the standard vector, and patterned words
    send_block('0, '0);
    send_block('1, '1);
    send_block(ShaIv, AbcBlock);
    send_block(ShaIv, '0);
    send_block(ShaIv, '1);
    send_block('1, '0);
    send_block('0, '1);
    send_block({8{32'haaaaaaaa}}, {16{32'h55555555}});
    send_block({8{32'h55555555}}, {16{32'haaaaaaaa}});
    send_block(256'h1, 512'h1);
    send_block({1'b1, 255'd0}, {1'b1, 511'd0});
    send_block({8{32'h80000000}}, {16{32'h00000001}});
    send_block({8{32'h7fffffff}}, {16{32'hfffffffe}});

    for (int i = 0; i < NumRandom; i++) begin
      if (i == LongHoldAt) hold_out = 1'b1;
      if (i == NumRandom - CalmTail) calm = 1'b1;
      send_block(rand_chain(), rand_msg());
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stall bursts, one long hold-off to fill the pipeline.
  initial begin
    out_ch.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    #(LimitCycles * 2);
    $display("TEST FAILED");
    $finish;
  end

endmodule
